>>> rtl/core/tmrc_pkg.sv
// Shared types and constants for the tile map row/column copier.
// No dependencies; imported by tile_map_row_column_copier.
`timescale 1ns / 1ps

package tmrc_pkg;

    // Default transfer lengths in byte pairs
    localparam int COLUMN_PAIRS_DEF   = 18;
    localparam int HALF_ROW_PAIRS_DEF = 10;

    // Configuration register indexes and reset values
    localparam logic CFG_SOURCE_BASE = 1'b0;
    localparam logic CFG_MAP_HIGH    = 1'b1;

    localparam logic [15:0] SOURCE_BASE_RST = 16'hCBFC;
    localparam logic [7:0]  MAP_HIGH_RST    = 8'h98;

    // Item kind carried on the input tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PAIR  = 1'b1;

    // Start request modes; any other value is a row
    localparam logic [7:0] REQ_OFF    = 8'd0;
    localparam logic [7:0] REQ_COLUMN = 8'd1;

    // Distance between tile map rows
    localparam logic [15:0] ROW_STRIDE = 16'd32;
    localparam logic [7:0]  ROW_STRIDE_LO = 8'd32;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_COLUMN = 2'd1,
        MODE_ROW    = 2'd2
    } mode_t;

    typedef struct packed {
        logic        last;
        mode_t       mode_taken;
        logic        write_valid;
        logic [15:0] fetch_addr;
        logic [7:0]  write_data_second;
        logic [15:0] write_addr_second;
        logic [7:0]  write_data_first;
        logic [15:0] write_addr_first;
    } result_t;

endpackage

>>> rtl/core/tile_map_row_column_copier.sv
// Tile map row/column copier: start items set up a copy, pair items emit two writes each.
// Depends on tmrc_pkg.
`timescale 1ns / 1ps
// The result of an accepted item is registered, in the result register or the skid entry.
// Throughput: one item per cycle while s_tready is high; the pointer update for a pair
// is a 16-bit add and masks, done in the cycle the item is accepted. A two-entry output
// stage (result + skid) keeps s_tready high while one result waits.
// Reset (rst_n, async, active low): idle, source pointer 0, both result entries empty,
// source_base = 0xCBFC, map_high = 0x98.

module tile_map_row_column_copier
    import tmrc_pkg::*;
#(
    parameter int COLUMN_PAIRS   = COLUMN_PAIRS_DEF,    // 1..31
    parameter int HALF_ROW_PAIRS = HALF_ROW_PAIRS_DEF   // 1..16
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_mode[7:0], dest_addr[23:8], byte_first[31:24],
                                   // byte_second[39:32]
    input  logic [0:0]  s_tuser,   // action[0]

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // write_addr_first[15:0], write_data_first[23:16],
                                   // write_addr_second[39:24], write_data_second[47:40],
                                   // fetch_addr[63:48]
    output logic [2:0]  m_tuser,   // write_valid[0], mode_taken[2:1]
    output logic        m_tlast
);

    // Pair counter just wide enough for the longest pass
    localparam int MAX_PAIRS = (COLUMN_PAIRS > HALF_ROW_PAIRS) ? COLUMN_PAIRS : HALF_ROW_PAIRS;
    localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
    localparam logic [CNT_W-1:0] COL_LOAD  = CNT_W'(COLUMN_PAIRS);
    localparam logic [CNT_W-1:0] HALF_LOAD = CNT_W'(HALF_ROW_PAIRS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // configuration
    logic [15:0] source_base_reg;
    logic [7:0]  map_high_reg;

    // transfer state
    mode_t            active_mode_reg, active_mode_next;
    logic [15:0]      source_ptr_reg, source_ptr_next;
    logic [15:0]      dest_ptr_reg, dest_ptr_next;
    logic [15:0]      saved_dest_reg, saved_dest_next;
    logic [CNT_W-1:0] pairs_left_reg, pairs_left_next;
    logic             second_half_reg, second_half_next;

    // output stage: result register plus skid entry
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    // input fields
    logic        action;
    logic [7:0]  req_mode;
    logic [15:0] dest_addr;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;

    logic    in_fire;
    logic    out_fire;
    result_t res;

    // pointer arithmetic
    logic [15:0] dest_inc;
    logic [15:0] col_dest;
    logic [15:0] row_dest;
    logic [15:0] half_dest;
    logic        pass_done;

    assign action      = s_tuser[0];
    assign req_mode    = s_tdata[7:0];
    assign dest_addr   = s_tdata[23:8];
    assign byte_first  = s_tdata[31:24];
    assign byte_second = s_tdata[39:32];

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Column: next row of the map, offset wraps in the 1 KB map
    assign dest_inc = dest_ptr_reg + 16'd1;
    assign col_dest = {map_high_reg[7:2], dest_ptr_reg[9:0] + ROW_STRIDE[9:0]};
    // Row: low 5 bits wrap inside the 32-byte row, carry from the pair is kept
    assign row_dest = {dest_inc[15:5], dest_inc[4:0] + 5'd1};
    // Second half: one row down, no carry into the high byte
    assign half_dest = {saved_dest_reg[15:8], saved_dest_reg[7:0] + ROW_STRIDE_LO};
    assign pass_done = (pairs_left_reg <= CNT_ONE);

    always_comb
    begin
        active_mode_next = active_mode_reg;
        source_ptr_next  = source_ptr_reg;
        dest_ptr_next    = dest_ptr_reg;
        saved_dest_next  = saved_dest_reg;
        pairs_left_next  = pairs_left_reg;
        second_half_next = second_half_reg;

        res = '0;
        res.mode_taken = MODE_IDLE;

        if (action == ACT_START) begin
            if (req_mode == REQ_OFF) begin
                active_mode_next = MODE_IDLE;
                res.last         = 1'b1;
            end
            else begin
                source_ptr_next  = source_base_reg;
                dest_ptr_next    = dest_addr;
                second_half_next = 1'b0;
                if (req_mode == REQ_COLUMN) begin
                    active_mode_next = MODE_COLUMN;
                    pairs_left_next  = COL_LOAD;
                    res.mode_taken   = MODE_COLUMN;
                end
                else begin
                    active_mode_next = MODE_ROW;
                    saved_dest_next  = dest_addr;
                    pairs_left_next  = HALF_LOAD;
                    res.mode_taken   = MODE_ROW;
                end
            end
        end
        else if (active_mode_reg == MODE_IDLE) begin
            // stray pair while idle: dropped
            res.last = 1'b1;
        end
        else begin
            res.write_valid       = 1'b1;
            res.write_addr_first  = dest_ptr_reg;
            res.write_data_first  = byte_first;
            res.write_addr_second = dest_inc;
            res.write_data_second = byte_second;
            res.mode_taken        = active_mode_reg;
            source_ptr_next       = source_ptr_reg + 16'd2;
            pairs_left_next       = pairs_left_reg - CNT_ONE;

            if (active_mode_reg == MODE_COLUMN) begin
                dest_ptr_next = col_dest;
                if (pass_done) begin
                    active_mode_next = MODE_IDLE;
                    res.last         = 1'b1;
                end
            end
            else begin
                dest_ptr_next = row_dest;
                if (pass_done) begin
                    if (!second_half_reg) begin
                        dest_ptr_next    = half_dest;
                        pairs_left_next  = HALF_LOAD;
                        second_half_next = 1'b1;
                    end
                    else begin
                        active_mode_next = MODE_IDLE;
                        res.last         = 1'b1;
                    end
                end
            end
        end

        res.fetch_addr = source_ptr_next;
    end

    // Output stage: a new result lands in the result register when it is free or being
    // drained, else in the skid entry; the skid entry refills the result register.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else begin
                out_valid_next = 1'b0;
            end
        end

        if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            source_base_reg <= SOURCE_BASE_RST;
            map_high_reg    <= MAP_HIGH_RST;
            active_mode_reg <= MODE_IDLE;
            source_ptr_reg  <= '0;
            pairs_left_reg  <= '0;
            second_half_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SOURCE_BASE) begin
                    source_base_reg <= cfg_wdata;
                end
                else begin
                    map_high_reg <= cfg_wdata[7:0];
                end
            end
            if (in_fire) begin
                active_mode_reg <= active_mode_next;
                source_ptr_reg  <= source_ptr_next;
                pairs_left_reg  <= pairs_left_next;
                second_half_reg <= second_half_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload: pointers only read while a transfer is active, results only while valid
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            dest_ptr_reg   <= dest_ptr_next;
            saved_dest_reg <= saved_dest_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.fetch_addr, out_reg.write_data_second, out_reg.write_addr_second,
                       out_reg.write_data_first, out_reg.write_addr_first};
    assign m_tuser  = {out_reg.mode_taken, out_reg.write_valid};
    assign m_tlast  = out_reg.last;

    // ---------------------------------------------------------------- checks

    // skid entry is only used behind a full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // an active transfer always has at least one pair left in its pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_mode_reg != MODE_IDLE) |-> (pairs_left_reg != '0))
        else $error("active transfer with empty pair count");

    // the second half only exists for rows
    assert property (@(posedge clk) disable iff (!rst_n)
        second_half_reg |-> (active_mode_reg != MODE_COLUMN))
        else $error("second half flag set during a column");

    // a result with writes always names the mode that produced it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] != MODE_IDLE))
        else $error("write result without a transfer mode");

endmodule

>>> tb/sv/tile_map_row_column_copier_tb.sv
// Self-checking bench for tile_map_row_column_copier: a directed stimulus table, then
// random transfers under several register settings, checked against a local predictor.
// Depends on tmrc_pkg and the copier RTL.
`timescale 1ns / 1ps

module tile_map_row_column_copier_tb;
    import tmrc_pkg::*;

    localparam int COL_PAIRS      = COLUMN_PAIRS_DEF;
    localparam int HALF_PAIRS     = HALF_ROW_PAIRS_DEF;
    localparam int ITEMS_PER_SET  = 280;    // random items per register setting
    localparam int SETTLE_CYCLES  = 4;      // idle wait after the last expected result
    localparam int QUIET_LIMIT    = 2000;   // cycles with no handshake before giving up

    // One input item plus, for directed rows, a result typed in by hand
    typedef struct {
        logic        act;
        logic [7:0]  mode;
        logic [15:0] dest;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        typed;
        result_t     want;
    } copy_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_SOURCE_BASE;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'h0;    // req_mode[7:0], dest_addr[23:8], byte_first[31:24],
                                     // byte_second[39:32]
    logic [0:0]  s_tuser = ACT_START; // action[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // write_addr_first[15:0], write_data_first[23:16],
                                     // write_addr_second[39:24], write_data_second[47:40],
                                     // fetch_addr[63:48]
    logic [2:0]  m_tuser;            // write_valid[0], mode_taken[2:1]
    logic        m_tlast;

    tile_map_row_column_copier #(
        .COLUMN_PAIRS   (COL_PAIRS),
        .HALF_ROW_PAIRS (HALF_PAIRS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: mirror of the copier state and its two registers
    // ------------------------------------------------------------------
    logic [15:0] base_copy;
    logic [7:0]  map_copy;
    mode_t       cur_mode;
    logic [15:0] src_ptr;
    logic [15:0] dst_ptr;
    logic [4:0]  pairs_to_go;
    logic [15:0] row_start;
    logic        in_second_half;

    copy_item_t  copy_items[$];       // items waiting to be sent
    result_t     copy_results_due[$]; // results expected, oldest first
    int          mismatches = 0;
    int          burst_left = 0;

    // Works out the result of one accepted item and advances the mirrored state.
    function automatic result_t next_copy_result(input logic act, input logic [7:0] mode,
                                                 input logic [15:0] dest,
                                                 input logic [7:0] b0, input logic [7:0] b1);
        result_t     r;
        logic [15:0] nxt;
        logic [15:0] col_off;
        logic [7:0]  lo;
        logic [7:0]  lo_inc;
        logic        pass_done;
        r = '0;
        r.mode_taken = MODE_IDLE;
        if (act == ACT_START) begin
            if (mode == REQ_OFF) begin
                cur_mode = MODE_IDLE;
                r.last = 1'b1;
            end
            else begin
                src_ptr = base_copy;
                dst_ptr = dest;
                in_second_half = 1'b0;
                if (mode == REQ_COLUMN) begin
                    cur_mode = MODE_COLUMN;
                    pairs_to_go = 5'(COL_PAIRS);
                end
                else begin
                    cur_mode = MODE_ROW;
                    row_start = dest;
                    pairs_to_go = 5'(HALF_PAIRS);
                end
                r.mode_taken = cur_mode;
            end
        end
        else if (cur_mode == MODE_IDLE) begin
            // stray pair with nothing running: ignored
            r.last = 1'b1;
        end
        else begin
            nxt = dst_ptr + 16'd1;
            pass_done = (pairs_to_go <= 5'd1);
            r.write_valid       = 1'b1;
            r.write_addr_first  = dst_ptr;
            r.write_data_first  = b0;
            r.write_addr_second = nxt;
            r.write_data_second = b1;
            r.mode_taken        = cur_mode;
            src_ptr = src_ptr + 16'd2;
            pairs_to_go = pairs_to_go - 5'd1;
            if (cur_mode == MODE_COLUMN) begin
                // next map row, wrapping inside the 1 KiB map
                col_off = nxt + 16'd31;
                dst_ptr = {map_copy[7:2], col_off[9:0]};
                if (pass_done) begin
                    cur_mode = MODE_IDLE;
                    r.last = 1'b1;
                end
            end
            else begin
                // low 5 bits wrap inside the row; a carry from the pair is kept
                lo = nxt[7:0];
                lo_inc = lo + 8'd1;
                dst_ptr = {nxt[15:8], lo[7:5], lo_inc[4:0]};
                if (pass_done) begin
                    if (!in_second_half) begin
                        dst_ptr = {row_start[15:8], row_start[7:0] + ROW_STRIDE_LO};
                        pairs_to_go = 5'(HALF_PAIRS);
                        in_second_half = 1'b1;
                    end
                    else begin
                        cur_mode = MODE_IDLE;
                        r.last = 1'b1;
                    end
                end
            end
        end
        r.fetch_addr = src_ptr;
        return r;
    endfunction

    function automatic result_t res(input logic wv, input logic [15:0] wa0,
                                    input logic [7:0] wd0, input logic [15:0] wa1,
                                    input logic [7:0] wd1, input logic [15:0] fetch,
                                    input mode_t taken, input logic fin);
        result_t r;
        r.write_valid       = wv;
        r.write_addr_first  = wa0;
        r.write_data_first  = wd0;
        r.write_addr_second = wa1;
        r.write_data_second = wd1;
        r.fetch_addr        = fetch;
        r.mode_taken        = taken;
        r.last              = fin;
        return r;
    endfunction

    task automatic add_item(input logic act, input logic [7:0] mode, input logic [15:0] dest,
                            input logic [7:0] b0, input logic [7:0] b1,
                            input logic typed, input result_t want);
        copy_item_t it;
        it.act   = act;
        it.mode  = mode;
        it.dest  = dest;
        it.b0    = b0;
        it.b1    = b1;
        it.typed = typed;
        it.want  = want;
        copy_items.push_back(it);
    endtask

    // Mostly complete transfers with random content; the rest is noise: off
    // requests, stray pairs, restarts and transfers cut short.
    task automatic queue_random_items(input int count);
        int          n;
        int          pick;
        int          len;
        logic [7:0]  mode;
        logic [15:0] dest;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                dest = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    dest[4:0] = 5'h1F;    // pair straddles the row wrap
                if ($urandom_range(0, 1) == 0) begin
                    mode = REQ_COLUMN;
                    len = COL_PAIRS;
                end
                else begin
                    mode = 8'($urandom_range(2, 255));
                    len = 2 * HALF_PAIRS;
                end
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(0, len - 1);
                add_item(ACT_START, mode, dest, 8'($urandom), 8'($urandom), 1'b0, '0);
                n++;
                for (int i = 0; i < len; i++) begin
                    add_item(ACT_PAIR, 8'($urandom), 16'($urandom), 8'($urandom),
                             8'($urandom), 1'b0, '0);
                    n++;
                end
            end
            else if (pick < 88) begin
                add_item(ACT_START, REQ_OFF, 16'($urandom), 8'($urandom), 8'($urandom),
                         1'b0, '0);
                n++;
            end
            else if (pick < 96) begin
                add_item(ACT_PAIR, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                         1'b0, '0);
                n++;
            end
            else begin
                add_item(ACT_START, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                         1'b0, '0);
                n++;
            end
        end
    endtask

    // Sends the queued items in bursts with random gaps; each accepted item
    // gets its expected result queued.
    task automatic send_items();
        copy_item_t it;
        result_t    pred;
        int         gap;
        while (copy_items.size() != 0) begin
            it = copy_items.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tuser  <= it.act;
            s_tdata  <= {it.b1, it.b0, it.dest, it.mode};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            pred = next_copy_result(it.act, it.mode, it.dest, it.b0, it.b1);
            copy_results_due.push_back(it.typed ? it.want : pred);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (copy_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back; only called with nothing in flight.
    task automatic write_config(input logic [15:0] base, input logic [7:0] map_hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOURCE_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        base_copy = base;
        cfg_index <= CFG_MAP_HIGH;
        cfg_wdata <= {8'h00, map_hi};
        @(posedge clk);
        map_copy = map_hi;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls on a rotating 8-bit pattern, reloaded now and then
    // ------------------------------------------------------------------
    logic [7:0] ready_pattern = 8'hFF;
    int         pattern_span = 0;

    always @(posedge clk) begin
        if (pattern_span == 0) begin
            pattern_span = $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0:       ready_pattern = 8'hFF;                   // no stalls
                1:       ready_pattern = 8'($urandom) | 8'h01;
                2:       ready_pattern = 8'hAA;
                default: ready_pattern = 8'h81;                   // long stalls
            endcase
        end
        pattern_span--;
        ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
        m_tready <= ready_pattern[0];
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    result_t seen;
    result_t want;

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %h, got %h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            seen.write_addr_first  = m_tdata[15:0];
            seen.write_data_first  = m_tdata[23:16];
            seen.write_addr_second = m_tdata[39:24];
            seen.write_data_second = m_tdata[47:40];
            seen.fetch_addr        = m_tdata[63:48];
            seen.write_valid       = m_tuser[0];
            seen.mode_taken        = mode_t'(m_tuser[2:1]);
            seen.last              = m_tlast;
            if (copy_results_due.size() == 0) begin
                $error("result item with nothing expected: tdata %h tuser %h tlast %b",
                       m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else begin
                want = copy_results_due.pop_front();
                check_field("write_valid", 16'(want.write_valid), 16'(seen.write_valid));
                check_field("write_addr_first", want.write_addr_first,
                            seen.write_addr_first);
                check_field("write_data_first", 16'(want.write_data_first),
                            16'(seen.write_data_first));
                check_field("write_addr_second", want.write_addr_second,
                            seen.write_addr_second);
                check_field("write_data_second", 16'(want.write_data_second),
                            16'(seen.write_data_second));
                check_field("fetch_addr", want.fetch_addr, seen.fetch_addr);
                check_field("mode_taken", 16'(want.mode_taken), 16'(seen.mode_taken));
                check_field("last", 16'(want.last), 16'(seen.last));
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        base_copy      = SOURCE_BASE_RST;
        map_copy       = MAP_HIGH_RST;
        cur_mode       = MODE_IDLE;
        src_ptr        = 16'h0000;
        dst_ptr        = 16'h0000;
        pairs_to_go    = 5'd0;
        row_start      = 16'h0000;
        in_second_half = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset register values
        // stray pair right after reset: ignored, source pointer still zero
        add_item(ACT_PAIR, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
                 res(1'b0, 16'h0, 8'h0, 16'h0, 8'h0, 16'h0000, MODE_IDLE, 1'b1));
        // off request
        add_item(ACT_START, REQ_OFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
                 res(1'b0, 16'h0, 8'h0, 16'h0, 8'h0, 16'h0000, MODE_IDLE, 1'b1));
        // column at the top of the address space
        add_item(ACT_START, REQ_COLUMN, 16'hFFFF, 8'h00, 8'h00, 1'b1,
                 res(1'b0, 16'h0, 8'h0, 16'h0, 8'h0, 16'hCBFC, MODE_COLUMN, 1'b0));
        // first pair: second write address wraps to zero
        add_item(ACT_PAIR, 8'h00, 16'h0000, 8'h00, 8'hFF, 1'b1,
                 res(1'b1, 16'hFFFF, 8'h00, 16'h0000, 8'hFF, 16'hCBFE, MODE_COLUMN, 1'b0));
        // row request abandons the running column
        add_item(ACT_START, 8'hFF, 16'h12FF, 8'hFF, 8'h00, 1'b1,
                 res(1'b0, 16'h0, 8'h0, 16'h0, 8'h0, 16'hCBFC, MODE_ROW, 1'b0));
        // both row halves; the first pair carries into the high byte
        for (int i = 0; i < 2 * HALF_PAIRS; i++)
            add_item(ACT_PAIR, 8'h00, 16'h0000, i[0] ? 8'hFF : 8'h00,
                     i[0] ? 8'h00 : 8'hFF, 1'b0, '0);
        // pair after the row has finished
        add_item(ACT_PAIR, 8'hFF, 16'hFFFF, 8'h5A, 8'hA5, 1'b0, '0);

        queue_random_items(ITEMS_PER_SET);
        send_items();
        drain();

        // Further register settings: both extremes, then random ones
        for (int set = 1; set <= 4; set++) begin
            case (set)
                1:       write_config(16'hFFFF, 8'hFF);
                2:       write_config(16'h0000, 8'h00);
                3:       write_config(16'($urandom), 8'($urandom));
                default: write_config(16'($urandom), 8'($urandom) | 8'h03);
            endcase
            queue_random_items(ITEMS_PER_SET);
            send_items();
            drain();
        end

        if (copy_results_due.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
